// ===== rtl/core/bmhq_pkg.sv =====
// Shared types, codes and constants of the binary max-heap queue.
package bmhq_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 9;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 256;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] TOK_INS  = 2'd0;
    localparam logic [1:0] TOK_HOLE = 2'd1;
    localparam logic [1:0] TOK_DN   = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] max_value;
        logic [COUNT_W-1:0]       count;
    } t_out_item;

    typedef struct packed {
        logic                     vld;
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] value;
    } t_tok;

    typedef struct packed {
        logic                     we;
        logic signed [DATA_W-1:0] data;
    } t_upw;

endpackage

// ===== rtl/core/binary_max_heap_queue_core.sv =====
// Top level of the binary max-heap queue: sequencer and one cell per heap level.
//
// Channel  Dir  Handshake        Payload
// item     in   start, busy      i_item (kind, value)
// result   out  o_strobe         o_result (status, max_value, count)
//
// An item is taken when start is high and busy is low; each item gives one result.
// An insert moves down from the root to L, the level of the new element; a delete fetches
// the root and the last element and moves the last one down to D, the deepest level whose
// elements are compared with it (0 when the root has no children), or ends after the fetch
// when it empties. Full and empty cases skip the levels; a level costs a read and a compare.
// Reset empties the heap. The receiver cannot stall; a new item may enter as a result shows.
module binary_max_heap_queue_core #(
    parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bmhq_pkg::t_in_item  i_item,
    output bmhq_pkg::t_out_item o_result,
    output logic                o_strobe
);

    localparam int PW    = $clog2(CAPACITY + 1);
    localparam int CELLS = PW;

    bmhq_pkg::t_tok                         tok  [CELLS+1];
    logic [PW-1:0]                          tpos [CELLS+1];
    bmhq_pkg::t_upw                         up   [CELLS+1];
    logic [PW-1:0]                          upos [CELLS+1];
    logic [CELLS-1:0][bmhq_pkg::DATA_W-1:0] rd;
    logic [CELLS-1:0]                       done;
    logic [PW-1:0]                          lim;
    logic [PW-1:0]                          path;
    logic                                   probe;
    logic [PW-1:0]                          ppos;

    assign up[CELLS]   = '0;
    assign upos[CELLS] = '0;

    bmhq_seq #(
        .CAPACITY (CAPACITY),
        .PW       (PW),
        .CELLS    (CELLS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .o_busy   (busy),
        .o_result (o_result),
        .o_strobe (o_strobe),
        .o_tok    (tok[0]),
        .o_tpos   (tpos[0]),
        .o_lim    (lim),
        .o_path   (path),
        .o_probe  (probe),
        .o_ppos   (ppos),
        .i_rd     (rd),
        .i_done   (|done)
    );

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        bmhq_cell #(
            .LEVEL (k),
            .PW    (PW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (tok[k]),
            .i_pos      (tpos[k]),
            .i_lim      (lim),
            .i_path_bit (path[PW-1-k]),
            .i_probe    (probe),
            .i_ppos     (ppos),
            .i_up       (up[k+1]),
            .i_up_pos   (upos[k+1]),
            .o_tok      (tok[k+1]),
            .o_pos      (tpos[k+1]),
            .o_up       (up[k]),
            .o_up_pos   (upos[k]),
            .o_rd       (rd[k]),
            .o_done     (done[k])
        );
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(done))
        else $error("More than one level finished an item in the same cycle.");

    a_no_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tok[CELLS].vld)
        else $error("The deepest level handed an item past the end of the chain.");

    a_root_no_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !up[0].we)
        else $error("The root level issued a write above the root.");

    a_fell_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("The block went idle without presenting a result.");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|done) |-> busy)
        else $error("A level finished while no item was in progress.");
`endif

endmodule

// ===== rtl/core/bmhq_cell.sv =====
// One heap level: its memory, the compare step and the hand-off to the next level.
module bmhq_cell #(
    parameter int LEVEL = 0,
    parameter int PW    = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmhq_pkg::t_tok                      i_tok,
    input  logic [PW-1:0]                       i_pos,
    input  logic [PW-1:0]                       i_lim,
    input  logic                                i_path_bit,
    input  logic                                i_probe,
    input  logic [PW-1:0]                       i_ppos,
    input  bmhq_pkg::t_upw                      i_up,
    input  logic [PW-1:0]                       i_up_pos,
    output bmhq_pkg::t_tok                      o_tok,
    output logic [PW-1:0]                       o_pos,
    output bmhq_pkg::t_upw                      o_up,
    output logic [PW-1:0]                       o_up_pos,
    output logic signed [bmhq_pkg::DATA_W-1:0]  o_rd,
    output logic                                o_done
);

    localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
    localparam int DEPTH = 1 << AW;

    logic signed [bmhq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [bmhq_pkg::DATA_W-1:0] r_rda;
    logic signed [bmhq_pkg::DATA_W-1:0] r_rdb;

    logic                               r_act;
    logic                               n_act;
    logic [1:0]                         r_kind;
    logic [PW-1:0]                      r_pos;
    logic signed [bmhq_pkg::DATA_W-1:0] r_val;

    bmhq_pkg::t_tok                     r_fwd;
    bmhq_pkg::t_tok                     n_fwd;
    logic [PW-1:0]                      r_fpos;
    logic [PW-1:0]                      n_fpos;

    logic                               in_ins;
    logic                               in_hole;
    logic                               in_dn;
    logic                               in_fin;
    logic                               hole_kids;
    logic [PW:0]                        lim_x;
    logic [PW-1:0]                      lc_in;
    logic [PW-1:0]                      rc_in;
    logic [AW-1:0]                      ra;
    logic [AW-1:0]                      rb;

    logic                               act_ins;
    logic                               act_dn;
    logic                               swap;
    logic signed [bmhq_pkg::DATA_W-1:0] carry;
    logic [PW-1:0]                      lpos;
    logic [PW-1:0]                      rpos;
    logic                               rex;
    logic                               r_gt_l;
    logic                               l_gt_v;
    logic                               r_gt_v;
    logic                               take_r;
    logic signed [bmhq_pkg::DATA_W-1:0] cval;
    logic [PW-1:0]                      cpos;
    logic                               moves;
    logic                               lk;
    logic                               rk;
    logic                               ck;

    logic                               we;
    logic [AW-1:0]                      waddr;
    logic signed [bmhq_pkg::DATA_W-1:0] wdata;

    assign lim_x     = {1'b0, i_lim};
    assign in_ins    = i_tok.vld && (i_tok.kind == bmhq_pkg::TOK_INS);
    assign in_hole   = i_tok.vld && (i_tok.kind == bmhq_pkg::TOK_HOLE);
    assign in_dn     = i_tok.vld && (i_tok.kind == bmhq_pkg::TOK_DN);
    assign in_fin    = in_ins && (i_pos == i_lim);
    assign hole_kids = {i_pos, 1'b0} <= lim_x;
    assign lc_in     = {i_pos[PW-2:0], 1'b0};
    assign rc_in     = {i_pos[PW-2:0], 1'b1};

    always_comb begin
        if (i_probe) begin
            ra = i_ppos[AW-1:0];
        end else if (in_dn) begin
            ra = lc_in[AW-1:0];
        end else begin
            ra = i_pos[AW-1:0];
        end
        rb = rc_in[AW-1:0];
    end

    assign act_ins = r_act && (r_kind == bmhq_pkg::TOK_INS);
    assign act_dn  = r_act && (r_kind == bmhq_pkg::TOK_DN);
    assign swap    = r_val > r_rda;
    assign carry   = swap ? r_rda : r_val;

    assign lpos   = {r_pos[PW-2:0], 1'b0};
    assign rpos   = {r_pos[PW-2:0], 1'b1};
    assign rex    = {1'b0, rpos} <= lim_x;
    assign r_gt_l = r_rdb > r_rda;
    assign l_gt_v = r_rda > r_val;
    assign r_gt_v = r_rdb > r_val;
    assign take_r = rex && r_gt_l;
    assign cval   = take_r ? r_rdb : r_rda;
    assign cpos   = take_r ? rpos : lpos;
    assign moves  = take_r ? r_gt_v : l_gt_v;
    assign lk     = {lpos, 1'b0} <= lim_x;
    assign rk     = {rpos, 1'b0} <= lim_x;
    assign ck     = take_r ? rk : lk;

    assign o_up.we   = act_dn;
    assign o_up.data = moves ? cval : r_val;
    assign o_up_pos  = r_pos;

    assign o_done = in_fin || (in_hole && !hole_kids) || (act_dn && (!moves || !ck));

    always_comb begin
        we    = 1'b0;
        waddr = i_up_pos[AW-1:0];
        wdata = i_up.data;
        if (in_fin || (in_hole && !hole_kids)) begin
            we    = 1'b1;
            waddr = i_pos[AW-1:0];
            wdata = i_tok.value;
        end else if (act_ins && swap) begin
            we    = 1'b1;
            waddr = r_pos[AW-1:0];
            wdata = r_val;
        end else if (act_dn && moves && !ck) begin
            we    = 1'b1;
            waddr = cpos[AW-1:0];
            wdata = r_val;
        end else if (i_up.we) begin
            we    = 1'b1;
        end
    end

    always_comb begin
        n_act        = (in_ins && !in_fin) || in_dn;
        n_fwd.vld    = 1'b0;
        n_fwd.kind   = bmhq_pkg::TOK_DN;
        n_fwd.value  = r_val;
        n_fpos       = cpos;
        if (in_hole && hole_kids) begin
            n_fwd.vld   = 1'b1;
            n_fwd.value = i_tok.value;
            n_fpos      = i_pos;
        end else if (act_ins) begin
            n_fwd.vld   = 1'b1;
            n_fwd.kind  = bmhq_pkg::TOK_INS;
            n_fwd.value = carry;
            n_fpos      = {r_pos[PW-2:0], i_path_bit};
        end else if (act_dn && moves && ck) begin
            n_fwd.vld   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rda <= r_mem[ra];
        r_rdb <= r_mem[rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_fwd.vld <= 1'b0;
        end else begin
            r_act <= n_act;
            r_fwd <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fpos <= n_fpos;
        if (n_act) begin
            r_kind <= i_tok.kind;
            r_pos  <= i_pos;
            r_val  <= i_tok.value;
        end
    end

    assign o_tok = r_fwd;
    assign o_pos = r_fpos;
    assign o_rd  = r_rda;

endmodule

// ===== rtl/core/bmhq_seq.sv =====
// Command sequencer: count, path setup, root and last fetch, and the result register.
module bmhq_seq #(
    parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
    parameter int PW       = 9,
    parameter int CELLS    = 9
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  bmhq_pkg::t_in_item                    i_item,
    output logic                                  o_busy,
    output bmhq_pkg::t_out_item                   o_result,
    output logic                                  o_strobe,
    output bmhq_pkg::t_tok                        o_tok,
    output logic [PW-1:0]                         o_tpos,
    output logic [PW-1:0]                         o_lim,
    output logic [PW-1:0]                         o_path,
    output logic                                  o_probe,
    output logic [PW-1:0]                         o_ppos,
    input  logic [CELLS-1:0][bmhq_pkg::DATA_W-1:0] i_rd,
    input  logic                                  i_done
);

    localparam int LW = $clog2(CELLS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PR1  = 3'd1;
    localparam logic [2:0] S_PR2  = 3'd2;
    localparam logic [2:0] S_PR3  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    localparam logic [PW-1:0] CAP_V = PW'(CAPACITY);
    localparam logic [PW-1:0] ROOT  = PW'(1);

    logic [2:0]                         r_state;
    logic [2:0]                         n_state;
    logic [PW-1:0]                      r_count;
    logic [PW-1:0]                      n_count;
    logic [PW-1:0]                      r_lim;
    logic [PW-1:0]                      n_lim;
    logic [PW-1:0]                      r_path;
    logic [PW-1:0]                      n_path;
    logic [PW-1:0]                      r_last;
    logic [PW-1:0]                      n_last;
    logic [LW-1:0]                      r_lvl;
    logic [LW-1:0]                      n_lvl;
    logic signed [bmhq_pkg::DATA_W-1:0] r_max;
    logic signed [bmhq_pkg::DATA_W-1:0] n_max;
    bmhq_pkg::t_tok                     r_tok;
    bmhq_pkg::t_tok                     n_tok;
    logic [PW-1:0]                      r_tpos;
    logic [PW-1:0]                      n_tpos;
    logic                               r_probe;
    logic                               n_probe;
    logic [PW-1:0]                      r_ppos;
    logic [PW-1:0]                      n_ppos;
    logic                               r_strobe;
    logic                               n_strobe;
    bmhq_pkg::t_out_item                r_result;
    bmhq_pkg::t_out_item                n_result;

    logic [PW-1:0]                      cnt_inc;
    logic [PW-1:0]                      cnt_dec;
    logic [2*PW-1:0]                    path_full;

    function automatic logic [LW-1:0] lvl_of(input logic [PW-1:0] x);
        logic [LW-1:0] l;
        l = '0;
        for (int b = 0; b < PW; b++) begin
            if (x[b]) begin
                l = LW'(b);
            end
        end
        return l;
    endfunction

    assign cnt_inc   = r_count + ROOT;
    assign cnt_dec   = r_count - ROOT;
    assign path_full = {cnt_inc, PW'(0)} >> lvl_of(cnt_inc);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lim    = r_lim;
        n_path   = r_path;
        n_last   = r_last;
        n_lvl    = r_lvl;
        n_max    = r_max;
        n_tok    = r_tok;
        n_tok.vld = 1'b0;
        n_tpos   = r_tpos;
        n_probe  = r_probe;
        n_ppos   = r_ppos;
        n_strobe = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_result.max_value = '0;
                    n_result.count     = bmhq_pkg::COUNT_W'(r_count);
                    if (i_item.kind == bmhq_pkg::KIND_INSERT) begin
                        if (r_count == CAP_V) begin
                            n_result.status = bmhq_pkg::ST_FULL;
                            n_strobe        = 1'b1;
                        end else begin
                            n_count     = cnt_inc;
                            n_lim       = cnt_inc;
                            n_path      = path_full[PW-1:0];
                            n_max       = '0;
                            n_tok.vld   = 1'b1;
                            n_tok.kind  = bmhq_pkg::TOK_INS;
                            n_tok.value = i_item.value;
                            n_tpos      = ROOT;
                            n_state     = S_WAIT;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_result.status = bmhq_pkg::ST_EMPTY;
                            n_strobe        = 1'b1;
                        end else begin
                            n_count = cnt_dec;
                            n_lim   = cnt_dec;
                            n_last  = r_count;
                            n_lvl   = lvl_of(r_count);
                            n_probe = 1'b1;
                            n_ppos  = ROOT;
                            n_state = S_PR1;
                        end
                    end
                end
            end
            S_PR1: begin
                n_ppos  = r_last;
                n_state = S_PR2;
            end
            S_PR2: begin
                n_max   = i_rd[0];
                n_probe = 1'b0;
                n_state = S_PR3;
            end
            S_PR3: begin
                if (r_lim == '0) begin
                    n_result.status    = bmhq_pkg::ST_OK;
                    n_result.max_value = r_max;
                    n_result.count     = bmhq_pkg::COUNT_W'(r_count);
                    n_strobe           = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_tok.vld   = 1'b1;
                    n_tok.kind  = bmhq_pkg::TOK_HOLE;
                    n_tok.value = i_rd[r_lvl];
                    n_tpos      = ROOT;
                    n_state     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_done) begin
                    n_result.status    = bmhq_pkg::ST_OK;
                    n_result.max_value = r_max;
                    n_result.count     = bmhq_pkg::COUNT_W'(r_count);
                    n_strobe           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_tok.vld <= 1'b0;
            r_probe   <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_tok    <= n_tok;
            r_probe  <= n_probe;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= n_lim;
        r_path   <= n_path;
        r_last   <= n_last;
        r_lvl    <= n_lvl;
        r_max    <= n_max;
        r_tpos   <= n_tpos;
        r_ppos   <= n_ppos;
        r_result <= n_result;
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_result = r_result;
    assign o_strobe = r_strobe;
    assign o_tok    = r_tok;
    assign o_tpos   = r_tpos;
    assign o_lim    = r_lim;
    assign o_path   = r_path;
    assign o_probe  = r_probe;
    assign o_ppos   = r_ppos;

endmodule
